### rtl/lottery_scheduler_table_assert.svh
// assertion macros for the lottery scheduler table
// used by the top level; expects clk and rst_n in scope
`ifndef LOTTERY_SCHEDULER_TABLE_ASSERT_SVH
`define LOTTERY_SCHEDULER_TABLE_ASSERT_SVH

// same-cycle implication
`define LST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lst_pkg.sv
// shared types and constants of the lottery scheduler table
// no dependencies
package lst_pkg;

    localparam int MAX_JOBS = 64;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int SUM_W    = $clog2(MAX_JOBS * 1023 + 1);
    localparam int CMP_W    = (SUM_W > 16) ? SUM_W : 16;

    localparam logic       MODE_ADD  = 1'b0;
    localparam logic       MODE_DRAW = 1'b1;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_BEYOND = 2'd3;

    localparam logic [2:0] REG_QUANTUM  = 3'd0;
    localparam logic [2:0] REG_OVERHEAD = 3'd1;
    localparam logic [2:0] REG_CLASS_A  = 3'd2;
    localparam logic [2:0] REG_CLASS_B  = 3'd3;
    localparam logic [2:0] REG_CLASS_C  = 3'd4;

    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] remaining;
        logic [9:0]  tickets;
    } job_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_TAIL,
        CELL_LOAD
    } cell_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } state_t;

endpackage

### rtl/lst_cell.sv
// one job slot of the table chain
// depends on lst_pkg
module lst_cell (
    input  logic              clk,
    input  lst_pkg::cell_sel_t sel,
    input  lst_pkg::job_t     neighbor,
    input  lst_pkg::job_t     tail,
    input  lst_pkg::job_t     load,
    output lst_pkg::job_t     job
);
    import lst_pkg::*;

    job_t job_reg;
    job_t job_next;

    always_comb
    begin
        case (sel)
            CELL_SHIFT: job_next = neighbor;
            CELL_TAIL:  job_next = tail;
            CELL_LOAD:  job_next = load;
            default:    job_next = job_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job = job_reg;

endmodule

### rtl/lottery_scheduler_table.sv
// lottery scheduler table: an add result is registered in the cycle after accept; a draw rotates the
// live jobs once through the cell chain, one cell per cycle, then passes the finish state before its
// result is registered (count = live jobs); errors are registered in the cycle after accept.
// one item is in work at a time; the output register lets the next item in.
// reset (async, active low) empties the table and restores register defaults.
`include "lottery_scheduler_table_assert.svh"
module lottery_scheduler_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // job_id[15:0], work_amount[31:16], ticket_count[41:32],
    // drawn_ticket[57:42], zero above
    input  logic [63:0] s_tdata,
    // mode[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // winner_id[15:0], charged_time[32:16], job_finished[33], job_class[35:34],
    // class_total[67:36], zero above
    output logic [71:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lst_pkg::*;

    logic [15:0] quantum_reg;
    logic [7:0]  overhead_reg;
    logic [9:0]  class_a_reg;
    logic [9:0]  class_b_reg;
    logic [9:0]  class_c_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] walk_left_reg, walk_left_next;
    logic [SUM_W-1:0] live_sum_reg, live_sum_next;
    logic [SUM_W-1:0] run_reg, run_next;
    logic             found_reg, found_next;
    logic [15:0]      drawn_reg, drawn_next;
    logic [15:0]      win_id_reg, win_id_next;
    logic [16:0]      win_charge_reg, win_charge_next;
    logic             win_fin_reg, win_fin_next;
    logic [9:0]       win_tk_reg, win_tk_next;
    logic [31:0]      totals_reg [4];
    logic [31:0]      totals_next [4];

    logic        out_valid_reg, out_valid_next;
    logic [67:0] out_data_reg, out_data_next;
    logic [1:0]  out_status_reg, out_status_next;

    job_t      cells [MAX_JOBS];
    cell_sel_t sel [MAX_JOBS];
    job_t      tail_job;
    job_t      new_job;
    logic      append_en;
    logic      step_en;

    logic        s_acc;
    logic        cfg_wr;
    logic        hit;
    logic        fits;
    logic [1:0]  cls;
    logic [32:0] total_sum;
    logic [31:0] total_sat;

    assign s_acc   = s_tvalid && s_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign new_job = '{ident: s_tdata[15:0], remaining: s_tdata[31:16],
                       tickets: s_tdata[41:32]};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg  <= 16'd20;
            overhead_reg <= 8'd1;
            class_a_reg  <= 10'd1;
            class_b_reg  <= 10'd5;
            class_c_reg  <= 10'd10;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_QUANTUM:  quantum_reg  <= pwdata[15:0];
                REG_OVERHEAD: overhead_reg <= pwdata[7:0];
                REG_CLASS_A:  class_a_reg  <= pwdata[9:0];
                REG_CLASS_B:  class_b_reg  <= pwdata[9:0];
                REG_CLASS_C:  class_c_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_QUANTUM:  prdata = {16'd0, quantum_reg};
            REG_OVERHEAD: prdata = {24'd0, overhead_reg};
            REG_CLASS_A:  prdata = {22'd0, class_a_reg};
            REG_CLASS_B:  prdata = {22'd0, class_b_reg};
            REG_CLASS_C:  prdata = {22'd0, class_c_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // job chain: cell 0 is the head examined by the walk
    for (genvar i = 0; i < MAX_JOBS; i++)
    begin : g_cell
        always_comb
        begin
            if (append_en && count_reg == CNT_W'(i))
                sel[i] = CELL_LOAD;
            else if (step_en && CNT_W'(i + 1) < count_reg)
                sel[i] = CELL_SHIFT;
            else if (step_en && CNT_W'(i + 1) == count_reg)
                sel[i] = CELL_TAIL;
            else
                sel[i] = CELL_HOLD;
        end

        lst_cell u_cell (
            .clk      (clk),
            .sel      (sel[i]),
            .neighbor ((i == MAX_JOBS - 1) ? tail_job : cells[(i + 1) % MAX_JOBS]),
            .tail     (tail_job),
            .load     (new_job),
            .job      (cells[i])
        );
    end

    // class of the winner and saturating total
    always_comb
    begin
        if (win_tk_reg == class_a_reg)
            cls = 2'd0;
        else if (win_tk_reg == class_b_reg)
            cls = 2'd1;
        else if (win_tk_reg == class_c_reg)
            cls = 2'd2;
        else
            cls = 2'd3;
        total_sum = {1'b0, totals_reg[cls]} + 33'(win_charge_reg);
        total_sat = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_left_next  = walk_left_reg;
        live_sum_next   = live_sum_reg;
        run_next        = run_reg;
        found_next      = found_reg;
        drawn_next      = drawn_reg;
        win_id_next     = win_id_reg;
        win_charge_next = win_charge_reg;
        win_fin_next    = win_fin_reg;
        win_tk_next     = win_tk_reg;
        totals_next     = totals_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        append_en       = 1'b0;
        step_en         = 1'b0;
        hit             = 1'b0;
        fits            = cells[0].remaining <= quantum_reg;
        tail_job        = cells[0];
        s_tready        = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    out_data_next = '0;
                    if (s_tuser == MODE_ADD)
                    begin
                        out_valid_next = 1'b1;
                        if (count_reg == CNT_W'(MAX_JOBS))
                            out_status_next = STAT_FULL;
                        else
                        begin
                            out_status_next = STAT_OK;
                            append_en       = 1'b1;
                            count_next      = count_reg + 1'b1;
                            live_sum_next   = live_sum_reg + SUM_W'(new_job.tickets);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_EMPTY;
                    end
                    else if (CMP_W'(s_tdata[57:42]) > CMP_W'(live_sum_reg))
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_BEYOND;
                    end
                    else
                    begin
                        walk_left_next = count_reg;
                        run_next       = '0;
                        found_next     = 1'b0;
                        drawn_next     = s_tdata[57:42];
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                step_en  = 1'b1;
                run_next = run_reg + SUM_W'(cells[0].tickets);
                hit      = !found_reg && ((CMP_W'(run_next) >= CMP_W'(drawn_reg))
                                          || walk_left_reg == CNT_W'(1));
                if (hit)
                begin
                    found_next   = 1'b1;
                    win_id_next  = cells[0].ident;
                    win_tk_next  = cells[0].tickets;
                    win_fin_next = fits;
                    if (fits)
                    begin
                        // winner leaves the ring; the region shrinks by one
                        win_charge_next = 17'(cells[0].remaining) + 17'(overhead_reg);
                        count_next      = count_reg - 1'b1;
                        live_sum_next   = live_sum_reg - SUM_W'(cells[0].tickets);
                    end
                    else
                    begin
                        win_charge_next    = 17'(quantum_reg) + 17'(overhead_reg);
                        tail_job.remaining = cells[0].remaining - quantum_reg;
                    end
                end
                walk_left_next = walk_left_reg - 1'b1;
                if (walk_left_reg == CNT_W'(1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                totals_next[cls] = total_sat;
                out_valid_next   = 1'b1;
                out_status_next  = STAT_OK;
                out_data_next    = {total_sat, cls, win_fin_reg, win_charge_reg, win_id_reg};
                state_next       = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            walk_left_reg <= '0;
            live_sum_reg  <= '0;
            run_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
                totals_reg[k] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            walk_left_reg <= walk_left_next;
            live_sum_reg  <= live_sum_next;
            run_reg       <= run_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            totals_reg    <= totals_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drawn_reg      <= drawn_next;
        win_id_reg     <= win_id_next;
        win_charge_reg <= win_charge_next;
        win_fin_reg    <= win_fin_next;
        win_tk_reg     <= win_tk_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};
    assign m_tuser  = out_status_reg;

    `LST_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_JOBS), "table count overflow")
    `LST_ASSERT_NOW(a_ready_idle, s_tready, state_reg == ST_IDLE, "ready outside idle")
    `LST_ASSERT_NEXT(a_fin_result, state_reg == ST_FIN, m_tvalid, "draw result not presented")
    `LST_ASSERT_NEXT(a_add_grows, s_acc && s_tuser == MODE_ADD && count_reg != CNT_W'(MAX_JOBS), count_reg == $past(count_reg) + 1'b1, "add did not grow table")

endmodule
